[rtl/core/aes_pkg.sv]
// ----------------------------------------------------------------------------
// aes_pkg
// constants, tables and small helpers for the byte-serial aes encryption core
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned RkWords  = 60;
  localparam int unsigned RkAddrW  = 6;
  localparam int unsigned KeyRegs  = 4;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY0 = 3'd0,
    CFG_KEY1 = 3'd1,
    CFG_KEY2 = 3'd2,
    CFG_KEY3 = 3'd3,
    CFG_KSIZE = 3'd4
  } cfg_idx_e;

  // key size codes
  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_KCOPY = 6'b000010,
    ST_KEXP  = 6'b000100,
    ST_SUB   = 6'b001000,
    ST_COL   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] j);
    logic [7:0] r;
    unique case (j)
      4'd0:    r = 8'h8d;
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      4'd11:   r = 8'h8d;
      4'd12:   r = 8'h01;
      4'd13:   r = 8'h02;
      4'd14:   r = 8'h04;
      default: r = 8'h08;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // one mixcolumns column, byte 0 in bits 7:0
  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, o0, o1, o2, o3;
    a0 = c[7:0];
    a1 = c[15:8];
    a2 = c[23:16];
    a3 = c[31:24];
    o0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
    o1 = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
    o2 = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
    o3 = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    return {o3, o2, o1, o0};
  endfunction

endpackage

[rtl/core/aes_block_encrypt.sv]
// ----------------------------------------------------------------------------
// aes_block_encrypt
// byte-serial aes-128/192/256 encryption core with on-chip key expansion
// ----------------------------------------------------------------------------
// usage
//   config port: key words and key size are written through cfg_we_i; the
//   user must write them only while the core is idle; the core does not
//   enforce it; any key write marks the round keys stale
//   input channel: one 128-bit plaintext block per transfer; in_stall_o is
//   high while a block is in work, so one block is handled at a time
//   output channel: ciphertext held in an output register until transferred;
//   a stalled receiver leaves it in place, and the core may take the next
//   block meanwhile, holding its own result until the register is free
//   rounds: byte-serial subbytes through the single s-box (bypassed in the
//   first round), then mixcolumns (not in the first or last round) and key
//   addition a column at a time
//   key expansion: on the first block after a key write, the key is copied,
//   then further words pass the shared s-box, before encryption starts
//   reset: no output pending, round keys marked stale, key registers zero
// ----------------------------------------------------------------------------
module aes_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] plain_lo_i,
  input  logic [63:0] plain_hi_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] cipher_lo_o,
  output logic [63:0] cipher_hi_o
);
  import aes_pkg::*;

  state_e        state_q, state_d;
  logic [63:0]   key_q [KeyRegs];
  logic [1:0]    ksize_q;
  logic          keys_ready_q;

  logic [127:0]  s_q, t_q, kw_q;
  logic [255:0]  win_q;
  logic [23:0]   sw_q;
  logic [31:0]   rd_q;
  logic [31:0]   rk_mem [RkWords];
  logic [3:0]    cnt_q, rnd_q;
  logic [RkAddrW-1:0] ki_q;
  logic [2:0]    kmod_q;
  logic [3:0]    krc_q;
  logic          out_valid_q;
  logic [127:0]  cipher_q;

  // key size decode
  logic [2:0]         nkm1;
  logic [3:0]         nr;
  logic [RkAddrW-1:0] last_word;
  logic [31:0]        wnk;
  always_comb begin
    unique case (ksize_q)
      KS_128: begin
        nkm1 = 3'd3; nr = 4'd10; last_word = 6'd43; wnk = win_q[127:96];
      end
      KS_192: begin
        nkm1 = 3'd5; nr = 4'd12; last_word = 6'd51; wnk = win_q[191:160];
      end
      default: begin
        nkm1 = 3'd7; nr = 4'd14; last_word = 6'd59; wnk = win_q[255:224];
      end
    endcase
  end

  // key schedule word path
  logic        rot, dosub;
  logic [31:0] tprev, tin, sub_full, exp_word, copy_word;
  logic [63:0] copy_reg;
  assign tprev     = win_q[31:0];
  assign rot       = (kmod_q == 3'd0);
  assign dosub     = rot || ((ksize_q == KS_256) && (kmod_q == 3'd4));
  assign tin       = rot ? {tprev[7:0], tprev[31:8]} : tprev;
  assign copy_reg  = key_q[ki_q[2:1]];
  assign copy_word = ki_q[0] ? copy_reg[63:32] : copy_reg[31:0];

  // round byte selection, shiftrows folded into the read order
  logic [1:0] src_col;
  logic [3:0] s_idx;
  logic [7:0] s_byte, sb_in, sb_out, t_byte;
  logic       first_rnd, last_rnd;
  assign first_rnd = (rnd_q == 4'd0);
  assign last_rnd  = (rnd_q == nr);
  assign src_col   = cnt_q[3:2] + cnt_q[1:0];
  assign s_idx     = first_rnd ? cnt_q : {src_col, cnt_q[1:0]};
  assign s_byte    = s_q[8*s_idx +: 8];

  // single shared s-box
  assign sb_in  = (state_q == ST_KEXP) ? tin[8*cnt_q[1:0] +: 8] : s_byte;
  assign sb_out = SBOX[sb_in];
  assign t_byte = first_rnd ? s_byte : sb_out;

  assign sub_full = {sb_out, sw_q};
  assign exp_word = (dosub ? (sub_full ^ {24'd0, rot ? rcon(krc_q) : 8'h00}) : tprev) ^ wnk;

  // column path
  logic [31:0] col_out;
  assign col_out = ((first_rnd || last_rnd) ? t_q[31:0] : mix_col(t_q[31:0])) ^ kw_q[31:0];

  // round key store
  logic               rk_we, rk_re;
  logic [RkAddrW-1:0] rk_raddr;
  logic [31:0]        rk_wdata;
  assign rk_we    = (state_q == ST_KCOPY) || ((state_q == ST_KEXP) && (cnt_q == 4'd3));
  assign rk_wdata = (state_q == ST_KCOPY) ? copy_word : exp_word;
  assign rk_re    = (state_q == ST_SUB) && (cnt_q < 4'd4);
  assign rk_raddr = {rnd_q, cnt_q[1:0]};

  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      rk_mem[ki_q] <= rk_wdata;
    end
    if (rk_re) begin
      rd_q <= rk_mem[rk_raddr];
    end
  end

  logic in_fire, out_free;
  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = keys_ready_q ? ST_SUB : ST_KCOPY;
      ST_KCOPY: if (ki_q[2:0] == nkm1) state_d = ST_KEXP;
      ST_KEXP:  if ((cnt_q == 4'd3) && (ki_q == last_word)) state_d = ST_SUB;
      ST_SUB:   if (cnt_q == 4'd15) state_d = ST_COL;
      ST_COL:   if (cnt_q == 4'd3) state_d = last_rnd ? ST_DONE : ST_SUB;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      keys_ready_q <= 1'b0;
      ksize_q      <= KS_128;
      key_q        <= '{default: '0};
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      rnd_q        <= '0;
      ki_q         <= '0;
      kmod_q       <= '0;
      krc_q        <= '0;
    end else begin
      state_q <= state_d;

      // configuration writes, expected only while idle
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
            key_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
          end
          CFG_KSIZE: begin
            ksize_q <= (cfg_wdata_i[1:0] == 2'd3) ? KS_256 : cfg_wdata_i[1:0];
          end
          default: ;
        endcase
      end

      // any key or size write makes the schedule stale
      if (cfg_we_i && (cfg_idx_i <= CFG_KSIZE)) begin
        keys_ready_q <= 1'b0;
      end else if ((state_q == ST_KEXP) && (cnt_q == 4'd3) && (ki_q == last_word)) begin
        keys_ready_q <= 1'b1;
      end

      // result register: refill on the edge the old one leaves
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          rnd_q <= '0;
          ki_q  <= '0;
        end
        ST_KCOPY: begin
          ki_q <= ki_q + 6'd1;
          if (ki_q[2:0] == nkm1) begin
            cnt_q  <= '0;
            kmod_q <= '0;
            krc_q  <= 4'd1;
          end
        end
        ST_KEXP: begin
          if (cnt_q == 4'd3) begin
            cnt_q <= '0;
            ki_q  <= ki_q + 6'd1;
            if (kmod_q == nkm1) begin
              kmod_q <= '0;
              krc_q  <= krc_q + 4'd1;
            end else begin
              kmod_q <= kmod_q + 3'd1;
            end
            if (ki_q == last_word) begin
              rnd_q <= '0;
            end
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        ST_SUB: begin
          cnt_q <= cnt_q + 4'd1;
        end
        ST_COL: begin
          if (cnt_q == 4'd3) begin
            cnt_q <= '0;
            rnd_q <= rnd_q + 4'd1;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_q <= {plain_hi_i, plain_lo_i};
    end
    if ((state_q == ST_KCOPY) || ((state_q == ST_KEXP) && (cnt_q == 4'd3))) begin
      win_q <= {win_q[223:0], rk_wdata};
    end
    if ((state_q == ST_KEXP) && (cnt_q != 4'd3)) begin
      sw_q <= {sb_out, sw_q[23:8]};
    end
    if (state_q == ST_SUB) begin
      t_q <= {t_byte, t_q[127:8]};
      if ((cnt_q != 4'd0) && (cnt_q < 4'd5)) begin
        kw_q <= {rd_q, kw_q[127:32]};
      end
    end
    if (state_q == ST_COL) begin
      s_q  <= {col_out, s_q[127:32]};
      t_q  <= {32'd0, t_q[127:32]};
      kw_q <= {32'd0, kw_q[127:32]};
    end
    if ((state_q == ST_DONE) && out_free) begin
      cipher_q <= s_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cipher_lo_o = cipher_q[63:0];
  assign cipher_hi_o = cipher_q[127:64];

endmodule

[dv/aes_block_encrypt_checker.sv]
// ----------------------------------------------------------------------------
// aes_block_encrypt_checker
// watches the key port and both channels of the aes core, computes the
// expected ciphertext of every accepted block and compares the results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_block_encrypt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] plain_lo_i,
  input  logic [63:0] plain_hi_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] cipher_lo_i,
  input  logic [63:0] cipher_hi_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import aes_pkg::*;

  localparam logic [7:0] RconTab [11] = '{
    8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } block_t;

  logic [7:0]  sbox_tab [256];
  logic [63:0] key_reg [KeyRegs];
  logic [1:0]  key_sel;
  logic [31:0] sched [RkWords];
  logic        sched_valid;
  block_t      cipher_q [$];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  // inverse as x^254, then the affine map
  function automatic logic [7:0] sbox_of(input logic [7:0] x);
    logic [7:0] r, base;
    int e;
    r = 8'h01;
    base = x;
    e = 254;
    while (e != 0) begin
      if (e & 1) r = gmul(r, base);
      base = gmul(base, base);
      e = e >> 1;
    end
    if (x == 8'h00) r = 8'h00;
    return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
           ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
  endfunction

  function automatic int key_words_of(input logic [1:0] ks);
    return (ks == KS_128) ? 4 : ((ks == KS_192) ? 6 : 8);
  endfunction

  function automatic void expand_schedule();
    int nk, total;
    logic [31:0] t;
    nk = key_words_of(key_sel);
    total = 4 * (nk + 7);
    for (int i = 0; i < nk; i++) sched[i] = 32'(key_reg[i / 2] >> (32 * (i % 2)));
    for (int i = nk; i < total; i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sub_w({t[7:0], t[31:8]}) ^ {24'h0, RconTab[(i / nk) % 11]};
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
    sched_valid = 1'b1;
  endfunction

  function automatic block_t encrypt_block(input logic [63:0] lo, input logic [63:0] hi);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [31:0] w;
    int nr;
    block_t res;
    nr = key_words_of(key_sel) + 6;
    for (int i = 0; i < 8; i++) begin
      s[i] = lo[8*i +: 8];
      s[8 + i] = hi[8*i +: 8];
    end
    for (int r = 0; r <= nr; r++) begin
      if (r > 0) begin
        // subbytes with shiftrows
        for (int c = 0; c < 4; c++)
          for (int b = 0; b < 4; b++) t[4*c + b] = sbox_tab[s[4*((c + b) % 4) + b]];
        s = t;
        if (r < nr) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c + 1]; a2 = s[4*c + 2]; a3 = s[4*c + 3];
            s[4*c]     = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
            s[4*c + 1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
            s[4*c + 2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
            s[4*c + 3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
          end
        end
      end
      for (int c = 0; c < 4; c++) begin
        w = sched[4*r + c];
        for (int b = 0; b < 4; b++) s[4*c + b] ^= w[8*b +: 8];
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.lo[8*i +: 8] = s[i];
      res.hi[8*i +: 8] = s[8 + i];
    end
    return res;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_of(8'(i));
  end

  always @(posedge clk_i or negedge rst_ni) begin
    block_t want;
    if (!rst_ni) begin
      for (int i = 0; i < KeyRegs; i++) key_reg[i] = '0;
      key_sel = KS_128;
      sched_valid = 1'b0;
      cipher_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < CFG_KSIZE) begin
          key_reg[cfg_idx_i[1:0]] = cfg_wdata_i;
          sched_valid = 1'b0;
        end else if (cfg_idx_i == CFG_KSIZE) begin
          // key size three saturates to the 256-bit schedule
          key_sel = (cfg_wdata_i[1:0] == 2'd3) ? KS_256 : cfg_wdata_i[1:0];
          sched_valid = 1'b0;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (!sched_valid) expand_schedule();
        cipher_q.push_back(encrypt_block(plain_lo_i, plain_hi_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          $error("ciphertext transfer with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = cipher_q.pop_front();
          if (cipher_lo_i !== want.lo)
            $error("cipher_lo mismatch: expected %h, actual %h", want.lo, cipher_lo_i);
          if (cipher_hi_i !== want.hi)
            $error("cipher_hi mismatch: expected %h, actual %h", want.hi, cipher_hi_i);
          if (cipher_lo_i !== want.lo || cipher_hi_i !== want.hi)
            fail_count_o <= fail_count_o + 1;
        end
        checked_o <= checked_o + 1;
      end
      pending_o <= cipher_q.size();
    end
  end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// aes encryption core test: directed blocks over every key size, then random
// keys and plaintexts under varying idle and stall patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import aes_pkg::*;

  // worst block: 256-bit expansion plus fourteen rounds, rounded up
  localparam int DrainCycles  = 600;
  localparam int QuietLimit   = 20000;
  localparam int HoldCycles   = 1500;
  localparam int RandPhases   = 8;
  localparam int PhaseBlocks  = 75;
  localparam int FirstUnusedIdx = 5;
  localparam int LastIdx        = 7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] plain_lo_i;
  logic [63:0] plain_hi_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] cipher_lo_o;
  logic [63:0] cipher_hi_o;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct;
  int recv_stall_pct;
  int blocks_sent;
  int size_seen [4];
  logic hold_req;

  aes_block_encrypt dut (.*);

  aes_block_encrypt_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i (in_stall_o), .plain_lo_i, .plain_hi_i,
    .out_valid_i (out_valid_o), .out_stall_i, .cipher_lo_i (cipher_lo_o),
    .cipher_hi_i (cipher_hi_o),
    .fail_count_o (fail_count), .pending_o (pending), .checked_o (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_left == 0) hold_left = HoldCycles;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transfer on any port
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QuietLimit) begin
        $display("aes_block_encrypt test failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // plaintext half with extremes mixed in
  function automatic logic [63:0] pick_half();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return 64'h5555_5555_5555_5555;
      default: return rand64();
    endcase
  endfunction

  // called at a rising edge; raises the write enable, then drops it before returning
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_KSIZE) size_seen[data[1:0]]++;
  endtask

  task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3,
                          input logic [63:0] ks);
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_KSIZE, ks);
  endtask

  // offer one block; valid stays high into the next call when no gap is drawn
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    plain_lo_i <= lo;
    plain_hi_i <= hi;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    blocks_sent++;
  endtask

  // let every ciphertext come back before touching the key
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_KEY0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    plain_lo_i = '0;
    plain_hi_i = '0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    blocks_sent = 0;
    for (int i = 0; i < 4; i++) size_seen[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key: all-zero 128-bit
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    drain();

    // every key size, key size three behaving as 256
    for (int ks = 0; ks < 4; ks++) begin
      load_key(rand64(), rand64(), rand64(), rand64(), 64'(ks));
      send_block('0, '1);
      send_block(rand64(), rand64());
      drain();
    end

    // all-ones key at 256 bits, then all-zero at 192
    load_key('1, '1, '1, '1, 64'(KS_256));
    send_block('1, '0);
    drain();
    load_key('0, '0, '0, '0, 64'(KS_192));
    send_block('1, '1);
    drain();

    // short key: the upper key words change nothing but force a new schedule
    load_key(rand64(), rand64(), rand64(), rand64(), 64'(KS_128));
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    drain();
    write_reg(CFG_KEY3, rand64());
    write_reg(CFG_KEY2, rand64());
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    drain();

    // writes to unmapped indexes leave the schedule alone
    for (int i = FirstUnusedIdx; i <= LastIdx; i++) write_reg(3'(i), rand64());
    send_block(rand64(), rand64());
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      set_mode(ph);
      // size field with random upper bits; extreme keys now and then
      if (ph == 3) load_key('1, '0, '1, '0, {$urandom(), $urandom()} | 64'h3);
      else load_key(rand64(), rand64(), rand64(), rand64(), rand64());
      for (int n = 0; n < PhaseBlocks; n++) begin
        if (ph == 1 && n == 10) begin
          // long receiver hold-off while blocks keep coming
          in_valid_i <= 1'b0;
          hold_req <= 1'b1;
          @(posedge clk_i);
          hold_req <= 1'b0;
        end
        if (n == PhaseBlocks / 2) begin
          // sender pause until all ciphertext is back, then a write to a key word, the key size or an unmapped index
          drain();
          case ($urandom_range(2))
            0: write_reg(3'($urandom_range(FirstUnusedIdx, LastIdx)), rand64());
            1: write_reg(3'($urandom_range(0, KeyRegs - 1)), rand64());
            default: write_reg(CFG_KSIZE, rand64());
          endcase
        end
        // unbroken traffic from block 50 of a phase on
        if (n % 25 == 0 && ph % 4 != 0) begin
          send_idle_pct = (n == 50) ? 0 : send_idle_pct;
        end
        send_block(pick_half(), pick_half());
      end
      drain();
    end

    $display("sent %0d blocks, checked %0d ciphertexts", blocks_sent, checked);
    $display("key size writes 128/192/256/three: %0d %0d %0d %0d",
             size_seen[0], size_seen[1], size_seen[2], size_seen[3]);
    if (fail_count == 0 && pending == 0) begin
      $display("aes_block_encrypt test passed");
    end else begin
      $display("aes_block_encrypt test failed");
    end
    $finish;
  end

endmodule
